// File: rtl/branch_outcome_evaluator_macros.svh
// ----------------------------------------------------------------------------
// Branch outcome evaluator assertion macros
// Shared concurrent assertion forms. All of them sample on clk and are off
// while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef BRANCH_OUTCOME_EVALUATOR_MACROS_SVH
`define BRANCH_OUTCOME_EVALUATOR_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BOE_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("branch evaluator same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define BOE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("branch evaluator next-cycle check failed");

`endif

// File: rtl/boe_pkg.sv
// ----------------------------------------------------------------------------
// Branch outcome evaluator package
// Opcodes of the branch format and the records carried between the
// pipeline stages.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package boe_pkg;

    // Field widths of the instruction word and the datapath.
    localparam int InstWidth = 32;
    localparam int PcWidth   = 32;
    localparam int DataWidth = 64;
    localparam int OpWidth   = 6;
    localparam int RegWidth  = 5;
    localparam int DispWidth = 21;

    // Opcodes of the branch and jump group.
    localparam logic [OpWidth-1:0] OP_JMP  = 6'h1a;
    localparam logic [OpWidth-1:0] OP_BR   = 6'h30;
    localparam logic [OpWidth-1:0] OP_FBEQ = 6'h31;
    localparam logic [OpWidth-1:0] OP_FBLT = 6'h32;
    localparam logic [OpWidth-1:0] OP_FBLE = 6'h33;
    localparam logic [OpWidth-1:0] OP_BSR  = 6'h34;
    localparam logic [OpWidth-1:0] OP_FBNE = 6'h35;
    localparam logic [OpWidth-1:0] OP_FBGE = 6'h36;
    localparam logic [OpWidth-1:0] OP_FBGT = 6'h37;
    localparam logic [OpWidth-1:0] OP_BLBC = 6'h38;
    localparam logic [OpWidth-1:0] OP_BEQ  = 6'h39;
    localparam logic [OpWidth-1:0] OP_BLT  = 6'h3a;
    localparam logic [OpWidth-1:0] OP_BLE  = 6'h3b;
    localparam logic [OpWidth-1:0] OP_BLBS = 6'h3c;
    localparam logic [OpWidth-1:0] OP_BNE  = 6'h3d;
    localparam logic [OpWidth-1:0] OP_BGE  = 6'h3e;
    localparam logic [OpWidth-1:0] OP_BGT  = 6'h3f;

    // Decoded item after the first stage.
    typedef struct packed {
        logic [OpWidth-1:0]  op;
        logic [RegWidth-1:0] ra;
        logic [PcWidth-1:0]  offset;
        logic [PcWidth-1:0]  pc;
        logic [PcWidth-1:0]  jump_target;
        logic                a_zero;
        logic                a_neg;
        logic                a_low;
        logic                f_nan;
        logic                f_zero;
        logic                f_neg;
    } decode_t;

    // Resolved item after the second stage.
    typedef struct packed {
        logic                is_jump;
        logic                taken;
        logic                link;
        logic                recog;
        logic [RegWidth-1:0] ra;
        logic [PcWidth-1:0]  pc;
        logic [PcWidth-1:0]  branch_target;
        logic [PcWidth-1:0]  jump_target;
    } resolve_t;

endpackage

`default_nettype wire

// File: rtl/boe_if.sv
// ----------------------------------------------------------------------------
// Branch outcome evaluator channels
// Valid/ready channels for the instruction items going in and the
// resolved branch items coming out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface boe_req_if;
    logic                                  valid;
    logic                                  ready;
    logic [boe_pkg::InstWidth-1:0]         instruction;
    logic [boe_pkg::PcWidth-1:0]           updated_pc;
    logic signed [boe_pkg::DataWidth-1:0]  int_ra_value;
    logic [boe_pkg::DataWidth-1:0]         int_rb_value;
    logic [boe_pkg::DataWidth-1:0]         float_ra_bits;

    modport source (
        output valid, instruction, updated_pc, int_ra_value, int_rb_value, float_ra_bits,
        input  ready
    );
    modport sink (
        input  valid, instruction, updated_pc, int_ra_value, int_rb_value, float_ra_bits,
        output ready
    );
endinterface

interface boe_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [boe_pkg::PcWidth-1:0]   next_pc;
    logic                          taken;
    logic                          link_write;
    logic [boe_pkg::RegWidth-1:0]  link_register;
    logic [boe_pkg::PcWidth-1:0]   link_value;
    logic                          recognized;

    modport source (
        output valid, next_pc, taken, link_write, link_register, link_value, recognized,
        input  ready
    );
    modport sink (
        input  valid, next_pc, taken, link_write, link_register, link_value, recognized,
        output ready
    );
endinterface

`default_nettype wire

// File: rtl/branch_outcome_evaluator.sv
// ----------------------------------------------------------------------------
// Branch outcome evaluator: three registered stages with a valid bit each.
// Throughput is one item per cycle, unless a low rsp.ready stalls the full output stage.
// Reset (rst_n low, asynchronous) empties all stages; no item is held across it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "branch_outcome_evaluator_macros.svh"

module branch_outcome_evaluator (
    input  wire        clk,
    input  wire        rst_n,
    boe_req_if.sink    req,
    boe_rsp_if.source  rsp
);

    // Stage valid bits and the advance chain. A stage may load when it is
    // empty or when its item moves on in the same cycle.
    logic s1_valid_reg;
    logic s2_valid_reg;
    logic s3_valid_reg;
    logic adv1;
    logic adv2;
    logic adv3;

    boe_pkg::decode_t  s1_reg;
    boe_pkg::decode_t  s1_next;
    boe_pkg::resolve_t s2_reg;
    boe_pkg::resolve_t s2_next;

    logic [boe_pkg::PcWidth-1:0]  next_pc_reg;
    logic [boe_pkg::PcWidth-1:0]  next_pc_next;
    logic                         taken_reg;
    logic                         link_write_reg;
    logic [boe_pkg::RegWidth-1:0] link_register_reg;
    logic [boe_pkg::RegWidth-1:0] link_register_next;
    logic [boe_pkg::PcWidth-1:0]  link_value_reg;
    logic [boe_pkg::PcWidth-1:0]  link_value_next;
    logic                         recognized_reg;

    assign adv3      = !s3_valid_reg || rsp.ready;
    assign adv2      = !s2_valid_reg || adv3;
    assign adv1      = !s1_valid_reg || adv2;
    assign req.ready = adv1;

    // Valid bits travel with the items.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
            begin
                s1_valid_reg <= req.valid;
            end
            if (adv2)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (adv3)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
        end
    end

    // Stage 1: split the instruction word and reduce the operands to flags.
    always_comb
    begin
        logic [boe_pkg::DispWidth-1:0] disp;
        logic                          f_exp_ones;
        logic                          f_frac_nz;
        disp               = req.instruction[boe_pkg::DispWidth-1:0];
        f_exp_ones         = &req.float_ra_bits[62:52];
        f_frac_nz          = |req.float_ra_bits[51:0];
        s1_next.op         = req.instruction[31:26];
        s1_next.ra         = req.instruction[25:21];
        s1_next.offset     = {{(boe_pkg::PcWidth - boe_pkg::DispWidth - 2){disp[20]}},
                              disp, 2'b00};
        s1_next.pc         = req.updated_pc;
        s1_next.jump_target = {req.int_rb_value[31:2], 2'b00};
        s1_next.a_zero     = (req.int_ra_value == '0);
        s1_next.a_neg      = req.int_ra_value[63];
        s1_next.a_low      = req.int_ra_value[0];
        s1_next.f_nan      = f_exp_ones && f_frac_nz;
        s1_next.f_zero     = (req.float_ra_bits[62:0] == '0);
        s1_next.f_neg      = req.float_ra_bits[63] && (req.float_ra_bits[62:0] != '0);
    end

    // Stage 2: test the condition and form the displacement target.
    always_comb
    begin
        s2_next.is_jump       = (s1_reg.op == boe_pkg::OP_JMP);
        s2_next.taken         = 1'b0;
        s2_next.link          = 1'b0;
        s2_next.recog         = 1'b1;
        s2_next.ra            = s1_reg.ra;
        s2_next.pc            = s1_reg.pc;
        s2_next.branch_target = s1_reg.pc + s1_reg.offset;
        s2_next.jump_target   = s1_reg.jump_target;
        unique case (s1_reg.op) inside
            boe_pkg::OP_JMP, boe_pkg::OP_BR, boe_pkg::OP_BSR:
            begin
                s2_next.taken = 1'b1;
                s2_next.link  = 1'b1;
            end
            boe_pkg::OP_FBEQ: s2_next.taken = !s1_reg.f_nan && s1_reg.f_zero;
            boe_pkg::OP_FBLT: s2_next.taken = !s1_reg.f_nan && s1_reg.f_neg;
            boe_pkg::OP_FBLE: s2_next.taken = !s1_reg.f_nan && (s1_reg.f_neg || s1_reg.f_zero);
            boe_pkg::OP_FBNE: s2_next.taken = s1_reg.f_nan || !s1_reg.f_zero;
            boe_pkg::OP_FBGE: s2_next.taken = !s1_reg.f_nan && !s1_reg.f_neg;
            boe_pkg::OP_FBGT: s2_next.taken = !s1_reg.f_nan && !s1_reg.f_neg && !s1_reg.f_zero;
            boe_pkg::OP_BLBC: s2_next.taken = !s1_reg.a_low;
            boe_pkg::OP_BEQ:  s2_next.taken = s1_reg.a_zero;
            boe_pkg::OP_BLT:  s2_next.taken = s1_reg.a_neg;
            boe_pkg::OP_BLE:  s2_next.taken = s1_reg.a_neg || s1_reg.a_zero;
            boe_pkg::OP_BLBS: s2_next.taken = s1_reg.a_low;
            boe_pkg::OP_BNE:  s2_next.taken = !s1_reg.a_zero;
            boe_pkg::OP_BGE:  s2_next.taken = !s1_reg.a_neg;
            boe_pkg::OP_BGT:  s2_next.taken = !s1_reg.a_neg && !s1_reg.a_zero;
            default:          s2_next.recog = 1'b0;
        endcase
    end

    // Stage 3: pick the next PC and the link write.
    always_comb
    begin
        if (s2_reg.is_jump)
        begin
            next_pc_next = s2_reg.jump_target;
        end
        else if (s2_reg.taken)
        begin
            next_pc_next = s2_reg.branch_target;
        end
        else
        begin
            next_pc_next = s2_reg.pc;
        end
        link_register_next = s2_reg.link ? s2_reg.ra : '0;
        link_value_next    = s2_reg.link ? s2_reg.pc : '0;
    end

    // Payload registers load with their stage and need no reset.
    always_ff @(posedge clk)
    begin
        if (adv1 && req.valid)
        begin
            s1_reg <= s1_next;
        end
        if (adv2 && s1_valid_reg)
        begin
            s2_reg <= s2_next;
        end
        if (adv3 && s2_valid_reg)
        begin
            next_pc_reg       <= next_pc_next;
            taken_reg         <= s2_reg.taken;
            link_write_reg    <= s2_reg.link;
            link_register_reg <= link_register_next;
            link_value_reg    <= link_value_next;
            recognized_reg    <= s2_reg.recog;
        end
    end

    assign rsp.valid         = s3_valid_reg;
    assign rsp.next_pc       = next_pc_reg;
    assign rsp.taken         = taken_reg;
    assign rsp.link_write    = link_write_reg;
    assign rsp.link_register = link_register_reg;
    assign rsp.link_value    = link_value_reg;
    assign rsp.recognized    = recognized_reg;

    // A link write only comes from a recognized, taken transfer.
    `BOE_ASSERT_SAME(a_link_taken, s3_valid_reg && link_write_reg, taken_reg && recognized_reg)
    // An unknown opcode neither branches nor links.
    `BOE_ASSERT_SAME(a_unknown_idle, s3_valid_reg && !recognized_reg, !taken_reg && !link_write_reg)
    // Without a link write the link fields stay clear.
    `BOE_ASSERT_SAME(a_link_clear, s3_valid_reg && !link_write_reg,
        link_register_reg == '0 && link_value_reg == '0)
    // A middle-stage item blocked by the output stage is kept.
    `BOE_ASSERT_NEXT(a_s2_hold, s2_valid_reg && !adv3, s2_valid_reg)

endmodule

`default_nettype wire
